/* design/pbc_pkg.sv */
// ----------------------------------------------------------------------------
// pbc_pkg: shared types and constants for the projected box cull block
// Request payload structs, function and outcome codes, register indexes.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int unsigned BOX_TYPES_DEF = 8;
  localparam int unsigned REG_W         = 12;
  localparam int unsigned IDX_W         = 3;

  localparam logic signed [31:0] NEAR_LIMIT = 32'sh100;
  localparam logic signed [31:0] POS_BIG    = 32'sh7FFFFFFF;
  localparam logic signed [31:0] NEG_BIG    = -32'sh7FFFFFFF;
  localparam logic signed [13:0] CULL_MARGIN = 14'sd8;
  localparam logic signed [32:0] MIN_PIXELS  = 33'sd3;

  localparam logic [1:0] FN_BOX  = 2'd0;
  localparam logic [1:0] FN_MAT  = 2'd1;
  localparam logic [1:0] FN_TEST = 2'd2;

  localparam logic [2:0] OC_WRITE   = 3'd0;
  localparam logic [2:0] OC_NOBOX   = 3'd1;
  localparam logic [2:0] OC_NEAR    = 3'd2;
  localparam logic [2:0] OC_OUTSIDE = 3'd3;
  localparam logic [2:0] OC_SMALL   = 3'd4;
  localparam logic [2:0] OC_VISIBLE = 3'd5;

  localparam logic [IDX_W-1:0] R_CX = 3'd0;
  localparam logic [IDX_W-1:0] R_CY = 3'd1;
  localparam logic [IDX_W-1:0] R_CL = 3'd2;
  localparam logic [IDX_W-1:0] R_CR = 3'd3;
  localparam logic [IDX_W-1:0] R_CT = 3'd4;
  localparam logic [IDX_W-1:0] R_CB = 3'd5;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         index;
    logic               box_valid;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic signed [31:0] v3;
    logic signed [31:0] v4;
    logic signed [31:0] v5;
  } in_req_t;

  typedef struct packed {
    logic               visible;
    logic [2:0]         outcome;
    logic signed [31:0] screen_min_x;
    logic signed [31:0] screen_min_y;
    logic signed [31:0] screen_max_x;
    logic signed [31:0] screen_max_y;
  } out_req_t;

endpackage

/* design/pbc_div.sv */
// ----------------------------------------------------------------------------
// pbc_div: iterative signed divider
// Restoring divide, one quotient bit per cycle, truncates toward zero.
// Numerator 40 bits signed, divisor 32 bits positive.
// ----------------------------------------------------------------------------
module pbc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [39:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic [31:0]        quo
);
  import pbc_pkg::*;

  logic [39:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r, d_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;
  logic [39:0] qneg;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[39]} - {2'b00, d_r};
    if (start) begin
      neg_nxt  = num[39];
      q_nxt    = num[39] ? (~num + 40'd1) : num;
      rem_nxt  = '0;
      d_nxt    = den;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        q_nxt   = {q_r[38:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[39]};
        q_nxt   = {q_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd39) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign qneg = ~q_r + 40'd1;
  assign done = done_r;
  assign quo  = neg_r ? qneg[31:0] : q_r[31:0];

endmodule

/* design/projected_box_cull.sv */
// ----------------------------------------------------------------------------
// projected_box_cull: screen-space bounding box visibility test
// Box table, world matrix, one shared multiplier and one iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//  in_valid/in_stall carry one request: func 0 writes a box entry, func 1 a
//  matrix row, func 2 tests a box type. Every request yields exactly one
//  out request (visible, outcome, screen rectangle).
//  cfg_we/cfg_addr/cfg_wdata write the six 12-bit registers (centre, clip);
//  indexes past the list are dropped. Write only while idle.
//  Sequence: a matrix write, an ignored write or a test without bounds goes
//  straight to the output stage; a box write stores its six words one per
//  cycle before its result. A test loads six words, then runs eight corners,
//  each nine multiplies on the shared 32x32 multiplier, two divides and an
//  update step, before the result reaches the output register. A near
//  corner ends the test early.
//  Throughput is one request at a time: in_stall is high while a request
//  is in flight, and low again once the result sits in the output
//  register, so a new request may enter while that result waits.
//  If the receiver holds out_stall, the result stays put and the block
//  holds any later result until the register empties.
//  Reset (rst_n low, synchronous) clears the box known bits, the matrix
//  and loads register defaults; box corner words are unwritten until set.
// ----------------------------------------------------------------------------
module projected_box_cull #(
  parameter int unsigned BOX_TYPES = pbc_pkg::BOX_TYPES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pbc_pkg::in_req_t                 in_req,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pbc_pkg::out_req_t                out_req,
  input  logic                             cfg_we,
  input  logic [pbc_pkg::IDX_W-1:0]        cfg_addr,
  input  logic [pbc_pkg::REG_W-1:0]        cfg_wdata
);
  import pbc_pkg::*;

  localparam int unsigned BW = (BOX_TYPES > 1) ? $clog2(BOX_TYPES) : 1;
  localparam int unsigned MD = 6 * BOX_TYPES;
  localparam int unsigned MW = $clog2(MD);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_DIVX = 9'b000001000,
    S_DIVY = 9'b000010000,
    S_ACC  = 9'b000100000,
    S_FIN  = 9'b001000000,
    S_OUT  = 9'b010000000,
    S_WBOX = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [REG_W-1:0] cx_r, cy_r, cl_r, cr_r, ct_r, cb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= 12'd212; cy_r <= 12'd120; cl_r <= 12'd0;
      cr_r <= 12'd424; ct_r <= 12'd0;   cb_r <= 12'd240;
    end else if (cfg_we) begin
      case (cfg_addr)
        R_CX: cx_r <= cfg_wdata;
        R_CY: cy_r <= cfg_wdata;
        R_CL: cl_r <= cfg_wdata;
        R_CR: cr_r <= cfg_wdata;
        R_CT: ct_r <= cfg_wdata;
        R_CB: cb_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // storage
  logic [31:0]          box_mem [MD];
  logic [BOX_TYPES-1:0] known_r;
  logic [31:0]          mat_r [12];
  logic [31:0]          bw_r [6];     // corner words of the box under test
  logic [31:0]          wv_r [6];     // words of a box write, stored in turn
  logic [31:0]          rd_r;
  logic [MW-1:0]        rd_addr;

  // request working registers
  logic [BW-1:0] sel_r;
  logic [2:0]  ld_r;
  logic [2:0]  corner_r;
  logic [3:0]  term_r;
  logic [31:0] acc_r;
  logic [31:0] vx_r, vy_r, vz_r;
  logic signed [31:0] sx_r, mnx_r, mny_r, mxx_r, mxy_r;
  out_req_t    res_r;
  logic        res_ld;
  out_req_t    res_val;
  logic        ov_r;

  wire accept = in_valid && !in_stall;
  wire idx_ok = ({3'b000, in_req.index} < 7'(BOX_TYPES));
  wire [BW-1:0] in_sel = BW'(in_req.index);

  // one word per cycle on writes, one registered read per cycle on loads
  always_ff @(posedge clk) begin
    if (state_r == S_WBOX) box_mem[rd_addr] <= wv_r[ld_r];
    rd_r <= box_mem[rd_addr];
  end

  assign rd_addr = MW'(sel_r) * MW'(6) + MW'(ld_r);

  // shared multiplier: term k of row r uses corner coord k and mat[r*4+k]
  logic [1:0]  row;
  logic [1:0]  col;
  logic [31:0] ma, mb;
  logic signed [63:0] prod;
  logic [31:0] term;
  always_comb begin
    case (term_r) inside
      [4'd0:4'd2]: row = 2'd0;
      [4'd3:4'd5]: row = 2'd1;
      default:     row = 2'd2;
    endcase
  end
  assign col = 2'(term_r - 4'(row) * 4'd3);
  always_comb begin
    case (col)
      2'd0:    ma = corner_r[2] ? bw_r[3] : bw_r[0];
      2'd1:    ma = corner_r[1] ? bw_r[4] : bw_r[1];
      default: ma = corner_r[0] ? bw_r[5] : bw_r[2];
    endcase
    mb = mat_r[4'(row) * 4'd4 + 4'(col)];
  end
  assign prod = $signed(ma) * $signed(mb);
  assign term = prod[39:8];

  // divider
  logic        dv_start, dv_done;
  logic signed [39:0] dv_num;
  logic [31:0] dv_quo;
  pbc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num),
    .den(vz_r), .done(dv_done), .quo(dv_quo)
  );
  logic dv_go_r;
  assign dv_start = dv_go_r;

  // screen coordinates and final tests
  logic signed [31:0] sy;
  assign sy = 32'({20'd0, cy_r}) - dv_quo;
  logic signed [13:0] lft, rgt, top, bot;
  assign lft = $signed({2'b00, cl_r}) - CULL_MARGIN;
  assign rgt = $signed({2'b00, cr_r}) + CULL_MARGIN;
  assign top = $signed({2'b00, ct_r}) - CULL_MARGIN;
  assign bot = $signed({2'b00, cb_r}) + CULL_MARGIN;
  logic signed [32:0] wdt, hgt;
  assign wdt = 33'(mxx_r) - 33'(mnx_r);
  assign hgt = 33'(mxy_r) - 33'(mny_r);

  always_comb begin
    state_nxt = state_r;
    res_ld = 1'b0;
    res_val = '0;
    case (state_r)
      S_IDLE: if (accept) begin
        if (in_req.func == FN_TEST) begin
          if (!idx_ok || !known_r[in_sel]) begin
            res_val.visible = 1'b1; res_val.outcome = OC_NOBOX; res_ld = 1'b1;
            state_nxt = S_OUT;
          end else state_nxt = S_LOAD;
        end else if (in_req.func == FN_BOX && idx_ok) begin
          state_nxt = S_WBOX;
        end else begin
          res_ld = 1'b1; res_val.outcome = OC_WRITE; state_nxt = S_OUT;
        end
      end
      S_WBOX: if (ld_r == 3'd5) begin
        res_ld = 1'b1; res_val.outcome = OC_WRITE; state_nxt = S_OUT;
      end
      S_LOAD: if (ld_r == 3'd6) state_nxt = S_MUL;
      S_MUL:  if (term_r == 4'd8) state_nxt = S_DIVX;
      S_DIVX: begin
        // the start cycle may still see a done from an abandoned divide
        if (!dv_go_r && $signed(vz_r) < NEAR_LIMIT) begin
          res_val.visible = 1'b1; res_val.outcome = OC_NEAR; res_ld = 1'b1;
          state_nxt = S_OUT;
        end else if (!dv_go_r && dv_done) state_nxt = S_DIVY;
      end
      S_DIVY: if (dv_done) state_nxt = S_ACC;
      S_ACC:  state_nxt = (corner_r == 3'd7) ? S_FIN : S_MUL;
      S_FIN: begin
        res_val.screen_min_x = mnx_r; res_val.screen_min_y = mny_r;
        res_val.screen_max_x = mxx_r; res_val.screen_max_y = mxy_r;
        if (mxx_r < 32'(lft) || mnx_r > 32'(rgt) ||
            mxy_r < 32'(top) || mny_r > 32'(bot))
          res_val.outcome = OC_OUTSIDE;
        else if (wdt < MIN_PIXELS || hgt < MIN_PIXELS)
          res_val.outcome = OC_SMALL;
        else begin
          res_val.outcome = OC_VISIBLE; res_val.visible = 1'b1;
        end
        res_ld = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (!ov_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register: loaded when free, else result held in res_r
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      known_r <= '0;
      ov_r    <= 1'b0;
      dv_go_r <= 1'b0;
      for (int k = 0; k < 12; k++) mat_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      dv_go_r <= 1'b0;
      if (accept && in_req.func == FN_BOX && idx_ok)
        known_r[in_sel] <= in_req.box_valid;
      if (accept && in_req.func == FN_MAT && in_req.index < 4'd3) begin
        mat_r[in_req.index * 4'd4]        <= in_req.v0;
        mat_r[in_req.index * 4'd4 + 4'd1] <= in_req.v1;
        mat_r[in_req.index * 4'd4 + 4'd2] <= in_req.v2;
        mat_r[in_req.index * 4'd4 + 4'd3] <= in_req.v3;
      end
      if (state_r == S_OUT && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      if (state_r == S_MUL && term_r == 4'd8) dv_go_r <= 1'b1;
      if (state_r == S_DIVX && !dv_go_r && dv_done) dv_go_r <= 1'b1;
    end
    if (state_r == S_OUT && (!ov_r || !out_stall)) out_req <= res_r;
    if (res_ld) res_r <= res_val;
    if (accept) begin
      wv_r[0] <= in_req.v0; wv_r[1] <= in_req.v1; wv_r[2] <= in_req.v2;
      wv_r[3] <= in_req.v3; wv_r[4] <= in_req.v4; wv_r[5] <= in_req.v5;
      sel_r <= in_sel;
      ld_r <= 3'd0;
      corner_r <= 3'd0;
      term_r <= 4'd0;
      mnx_r <= POS_BIG; mny_r <= POS_BIG;
      mxx_r <= NEG_BIG; mxy_r <= NEG_BIG;
    end
    if (state_r == S_WBOX) ld_r <= ld_r + 3'd1;
    if (state_r == S_LOAD) begin
      ld_r <= ld_r + 3'd1;
      if (ld_r != 3'd0) bw_r[ld_r - 3'd1] <= rd_r;
    end
    if (state_r == S_MUL) begin
      if (col == 2'd0) acc_r <= mat_r[4'(row) * 4'd4 + 4'd3] + term;
      else acc_r <= acc_r + term;
      if (col == 2'd2) begin
        case (row)
          2'd0:    vx_r <= acc_r + term;
          2'd1:    vy_r <= acc_r + term;
          default: vz_r <= acc_r + term;
        endcase
      end
      term_r <= term_r + 4'd1;
    end
    if (state_r == S_DIVX && !dv_go_r && dv_done) sx_r <= 32'({20'd0, cx_r}) + dv_quo;
    if (state_r == S_ACC) begin
      if (sx_r < mnx_r) mnx_r <= sx_r;
      if (sx_r > mxx_r) mxx_r <= sx_r;
      if (sy < mny_r) mny_r <= sy;
      if (sy > mxy_r) mxy_r <= sy;
      corner_r <= corner_r + 3'd1;
      term_r <= 4'd0;
    end
  end

  assign dv_num = (state_r == S_DIVX) ? {vx_r, 8'd0} : {vy_r, 8'd0};

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for projected_box_cull
// Drives box, matrix and test requests with random gaps and output stalls,
// predicts each result from a local copy of the box table, matrix and
// registers, and compares every result field by field in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbc_pkg::*;

  localparam int NBOX      = 8;
  localparam int RAND_REQS = 555;
  localparam int CYC_LIMIT = 2500000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_req;
  logic     cfg_we;
  logic [IDX_W-1:0] cfg_addr;
  logic [REG_W-1:0] cfg_wdata;

  projected_box_cull u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow state of the block
  logic signed [31:0] box_words [NBOX][6];
  logic               box_known [NBOX];
  logic signed [31:0] mat [12];
  logic [11:0]        centre_x, centre_y, clip_l, clip_r, clip_t, clip_b;

  out_req_t pending_results [$];
  int       errors;
  int       cycles;
  int       outcome_seen [6];
  int       sent;
  bit       quiet;      // when set, neither side idles

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] exp_v);
    errors++;
    $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, exp_v, cycles);
  endtask

  // 24.8 product term: (a*b) >>> 8 truncated to 32 bits
  function automatic logic [31:0] mat_term(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p[39:8];
  endfunction

  function automatic logic [31:0] xform_row(int row, logic signed [31:0] x,
                                            logic signed [31:0] y, logic signed [31:0] z);
    return mat[row*4+3] + mat_term(x, mat[row*4]) + mat_term(y, mat[row*4+1])
           + mat_term(z, mat[row*4+2]);
  endfunction

  // perspective divide, truncating towards zero
  function automatic logic [31:0] persp(logic signed [31:0] v, logic signed [31:0] d);
    longint q;
    q = (longint'(v) * 64'sd256) / longint'(d);
    return q[31:0];
  endfunction

  // Computes the result of one request and updates the shadow state
  function automatic out_req_t predict_cull(in_req_t r);
    out_req_t o;
    logic signed [31:0] b [6];
    logic signed [31:0] x, y, z, vz, sx, sy;
    logic [31:0] vx, vy;
    int mnx, mny, mxx, mxy;
    o = '0;
    case (r.func)
      FN_BOX: begin
        if (r.index < NBOX) begin
          box_known[r.index] = r.box_valid;
          box_words[r.index] = '{r.v0, r.v1, r.v2, r.v3, r.v4, r.v5};
        end
        return o;
      end
      FN_MAT: begin
        if (r.index < 3) begin
          mat[r.index*4]   = r.v0;
          mat[r.index*4+1] = r.v1;
          mat[r.index*4+2] = r.v2;
          mat[r.index*4+3] = r.v3;
        end
        return o;
      end
      FN_TEST: ;
      default: return o;
    endcase
    if (r.index >= NBOX || !box_known[r.index]) begin
      o.visible = 1'b1;
      o.outcome = OC_NOBOX;
      return o;
    end
    b = box_words[r.index];
    mnx = POS_BIG; mny = POS_BIG; mxx = NEG_BIG; mxy = NEG_BIG;
    for (int c = 0; c < 8; c++) begin
      x  = c[2] ? b[3] : b[0];
      y  = c[1] ? b[4] : b[1];
      z  = c[0] ? b[5] : b[2];
      vx = xform_row(0, x, y, z);
      vy = xform_row(1, x, y, z);
      vz = xform_row(2, x, y, z);
      if (vz < NEAR_LIMIT) begin
        o.visible = 1'b1;
        o.outcome = OC_NEAR;
        return o;
      end
      sx = {20'b0, centre_x} + persp(vx, vz);
      sy = {20'b0, centre_y} - persp(vy, vz);
      if (sx < mnx) mnx = sx;
      if (sy < mny) mny = sy;
      if (sx > mxx) mxx = sx;
      if (sy > mxy) mxy = sy;
    end
    o.screen_min_x = mnx;
    o.screen_min_y = mny;
    o.screen_max_x = mxx;
    o.screen_max_y = mxy;
    if (mxx < int'(clip_l) - 8 || mnx > int'(clip_r) + 8 ||
        mxy < int'(clip_t) - 8 || mny > int'(clip_b) + 8)
      o.outcome = OC_OUTSIDE;
    else if (longint'(mxx) - longint'(mnx) < 3 || longint'(mxy) - longint'(mny) < 3)
      o.outcome = OC_SMALL;
    else begin
      o.visible = 1'b1;
      o.outcome = OC_VISIBLE;
    end
    return o;
  endfunction

  // Result checker: oldest expectation against each accepted result
  always @(posedge clk) begin
    out_req_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("unexpected result, outcome %0d (cycle %0d)", out_req.outcome, cycles);
      end else begin
        e = pending_results.pop_front();
        if (out_req.visible !== e.visible)
          report("visible", out_req.visible, e.visible);
        if (out_req.outcome !== e.outcome)
          report("outcome", out_req.outcome, e.outcome);
        if (out_req.screen_min_x !== e.screen_min_x)
          report("screen_min_x", out_req.screen_min_x, e.screen_min_x);
        if (out_req.screen_min_y !== e.screen_min_y)
          report("screen_min_y", out_req.screen_min_y, e.screen_min_y);
        if (out_req.screen_max_x !== e.screen_max_x)
          report("screen_max_x", out_req.screen_max_x, e.screen_max_x);
        if (out_req.screen_max_y !== e.screen_max_y)
          report("screen_max_y", out_req.screen_max_y, e.screen_max_y);
        if (e.outcome <= OC_VISIBLE) outcome_seen[e.outcome]++;
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // Receiver stall pattern, changes at the falling edge
  initial begin
    int run;
    out_stall = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (run > 0) run--;
      else if (quiet) out_stall = 1'b0;
      else begin
        out_stall = ($urandom_range(0, 2) == 0);
        run = out_stall ? idle_len() : $urandom_range(0, 30);
      end
    end
  end

  // Sends one request; valid stays high when no gap follows
  task automatic send_req(in_req_t r);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_req   = r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_cull(r));
    sent++;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_req   = '0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drops valid first so the last request is not taken twice
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    in_req   = '0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, only called while drained
  task automatic reg_write(logic [IDX_W-1:0] a, logic [REG_W-1:0] d);
    @(negedge clk);
    in_valid  = 1'b0;
    cfg_we    = 1'b1;
    cfg_addr  = a;
    cfg_wdata = d;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (a)
      R_CX: centre_x = d;
      R_CY: centre_y = d;
      R_CL: clip_l   = d;
      R_CR: clip_r   = d;
      R_CT: clip_t   = d;
      R_CB: clip_b   = d;
      default: ;
    endcase
  endtask

  function automatic in_req_t mk(logic [1:0] f, logic [3:0] i, logic bv,
                                 int a0, int a1, int a2, int a3, int a4, int a5);
    in_req_t r;
    r = '{f, i, bv, a0, a1, a2, a3, a4, a5};
    return r;
  endfunction

  function automatic int srand(int w);
    return int'($urandom_range(0, 2*w)) - w;
  endfunction

  task automatic load_identity(int tz);
    send_req(mk(FN_MAT, 0, 0, 256, 0, 0, 0, 0, 0));
    send_req(mk(FN_MAT, 1, 0, 0, 256, 0, 0, 0, 0));
    send_req(mk(FN_MAT, 2, 0, 0, 0, 256, tz, 0, 0));
  endtask

  // Tests on an empty table: no bounds and near corners
  task automatic test_empty_table();
    send_req(mk(FN_TEST, 0, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(FN_TEST, 15, 1, -1, -1, -1, -1, -1, -1));
    send_req(mk(FN_BOX, 1, 1, 0, 0, 0, 10, 10, 10));
    send_req(mk(FN_TEST, 1, 0, 0, 0, 0, 0, 0, 0));   // zero matrix: near corner
  endtask

  // Writes that change nothing, and entries cleared again
  task automatic test_ignored_writes();
    send_req(mk(FN_BOX, 9, 1, 1, 2, 3, 4, 5, 6));
    send_req(mk(FN_TEST, 9, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(FN_MAT, 3, 0, -1, -1, -1, -1, -1, -1));
    send_req(mk(2'd3, 15, 1, -1, -1, -1, -1, -1, -1));
    send_req(mk(FN_BOX, 1, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(FN_TEST, 1, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Visible, too small, outside and near with a plain matrix
  task automatic test_outcomes();
    load_identity(1000);
    send_req(mk(FN_BOX, 0, 1, -50, -50, 0, 50, 50, 100));
    send_req(mk(FN_TEST, 0, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(FN_BOX, 2, 1, -2, -2, 0, 2, 2, 10));
    send_req(mk(FN_TEST, 2, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(FN_BOX, 3, 1, 100000, -50, 0, 100100, 50, 10));
    send_req(mk(FN_TEST, 3, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(FN_BOX, 4, 1, -50, -50, -900, 50, 50, 0));
    send_req(mk(FN_TEST, 4, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Extreme field values through the whole arithmetic path
  task automatic test_extremes();
    send_req(mk(FN_BOX, 7, 1, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    send_req(mk(FN_MAT, 2, 0, 0, 0, 1, 32'h7FFFFFFF, 0, 0));
    send_req(mk(FN_MAT, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0, 32'h80000000, 0, 0));
    send_req(mk(FN_TEST, 7, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(FN_MAT, 2, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0));
    send_req(mk(FN_TEST, 7, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Every register at its extremes, then back to ordinary values
  task automatic test_registers();
    drain();
    for (int a = 0; a < 8; a++) reg_write(a[IDX_W-1:0], 12'hFFF);
    load_identity(1000);
    send_req(mk(FN_BOX, 0, 1, -50, -50, 0, 50, 50, 100));
    send_req(mk(FN_TEST, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();
    for (int a = 0; a < 6; a++) reg_write(a[IDX_W-1:0], 12'h000);
    send_req(mk(FN_TEST, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();
    reg_write(R_CX, 212); reg_write(R_CY, 120); reg_write(R_CL, 0);
    reg_write(R_CR, 424); reg_write(R_CT, 0);   reg_write(R_CB, 240);
  endtask

  function automatic in_req_t rand_req();
    int r, row, cx, cy, cz, hx, hy, hz;
    in_req_t q;
    logic [223:0] noise;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // noise: any bits at all
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      q = noise[$bits(in_req_t)-1:0];
      return q;
    end
    if (r < 28) begin
      cx = srand(2000); cy = srand(2000); cz = srand(300);
      if ($urandom_range(0, 3) == 0) begin
        hx = $urandom_range(0, 4); hy = $urandom_range(0, 4);
      end else begin
        hx = $urandom_range(0, 400); hy = $urandom_range(0, 400);
      end
      hz = $urandom_range(0, 200);
      return mk(FN_BOX, 4'(($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) :
                $urandom_range(0, 7)), $urandom_range(0, 7) != 0,
                cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
    end
    if (r < 38) begin
      row = $urandom_range(0, 3);
      q = mk(FN_MAT, 4'(row), 1'($urandom), srand(80), srand(80), srand(80),
             (row == 2) ? int'($urandom_range(150, 6000)) : srand(3000),
             int'($urandom), int'($urandom));
      if (row < 3) begin
        if (row == 0) q.v0 = 256 + srand(80);
        if (row == 1) q.v1 = 256 + srand(80);
        if (row == 2) q.v2 = 256 + srand(80);
      end
      return q;
    end
    return mk(FN_TEST, 4'(($urandom_range(0, 19) == 0) ? $urandom_range(8, 15) :
              $urandom_range(0, 7)), 1'($urandom), int'($urandom), int'($urandom),
              int'($urandom), int'($urandom), int'($urandom), int'($urandom));
  endfunction

  // Random traffic, with a new register setting every hundred requests
  task automatic test_random();
    for (int n = 0; n < RAND_REQS; n++) begin
      if (n % 100 == 99) begin
        drain();
        for (int a = 0; a < 6; a++)
          reg_write(a[IDX_W-1:0], 12'(($urandom_range(0, 5) == 0) ?
                    ($urandom_range(0, 1) ? 12'hFFF : 12'h000) :
                    (a < 2 ? $urandom_range(50, 400) : $urandom_range(0, 500))));
        quiet = ($urandom_range(0, 2) == 0);
      end
      send_req(rand_req());
    end
    quiet = 1'b0;
  endtask

  initial begin
    errors = 0; cycles = 0; sent = 0; quiet = 1'b0;
    foreach (outcome_seen[i]) outcome_seen[i] = 0;
    foreach (box_known[i]) box_known[i] = 1'b0;
    foreach (box_words[i, j]) box_words[i][j] = '0;
    foreach (mat[i]) mat[i] = '0;
    centre_x = 212; centre_y = 120; clip_l = 0; clip_r = 424; clip_t = 0; clip_b = 240;
    in_valid = 1'b0; in_req = '0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_ignored_writes();
    test_outcomes();
    test_extremes();
    test_registers();
    test_random();

    @(negedge clk);
    in_valid = 1'b0;
    drain();
    repeat (800) @(posedge clk);

    $display("%0d requests sent; write %0d, no bounds %0d, near %0d", sent,
             outcome_seen[0], outcome_seen[1], outcome_seen[2]);
    $display("outside %0d, too small %0d, visible %0d, %0d mismatches",
             outcome_seen[3], outcome_seen[4], outcome_seen[5], errors);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
design/pbc_pkg.sv
design/pbc_div.sv
design/projected_box_cull.sv
bench/tb.sv
